// ===== rtl/cgc_pkg.sv =====
// Package for the Collatz glide counter: payload structs, constants, queue entry type.
// No dependencies.
`default_nettype none
package cgc_pkg;
  localparam int VALUE_BITS = 128;
  localparam int POW3_TABLE_LEN = 81;
  localparam int STEP_BITS = 16;
  localparam int HIGH_BITS = VALUE_BITS - 64;
  localparam int ALPHA_BITS = $clog2(VALUE_BITS + 1);
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
  localparam int Q_DEPTH = 2;
  localparam logic [1:0] CLS_EVEN = 2'd0;
  localparam logic [1:0] CLS_ONE = 2'd1;
  localparam logic [1:0] CLS_ITER = 2'd2;

  typedef struct packed {
    logic [63:0] start_low;
    logic [63:0] start_high;
    logic        restart_total;
  } cgc_in_t;

  typedef struct packed {
    logic [15:0] glide_steps;
    logic        overflow;
    logic        limit_hit;
    logic [63:0] step_total;
  } cgc_out_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [VALUE_BITS-1:0] start;
    logic                  restart;
    logic [1:0]            cls;
  } cgc_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INC, ST_STRIP_A, ST_MUL, ST_DEC, ST_STRIP_B, ST_CMP, ST_DONE
  } cgc_state_t;
endpackage
`default_nettype wire

// ===== rtl/collatz_glide_counter_unit.sv =====
// Top level of the Collatz glide counter: APB register, front end and back end.
// Depends on cgc_pkg, cgc_front, cgc_back.
//
// Channel | Ports                              | Transaction when
// input   | in_push, in_full, in_data          | in_push && !in_full
// result  | out_pop, out_empty, out_data       | out_pop && !out_empty
// config  | cfg_psel..cfg_prdata, cfg_pready   | psel && penable && pwrite
//
// Even and 1 mod 4 starts skip the iteration and go straight to the result write.
// Other starts repeat, per iteration, increment, first strip, alpha triplings,
// decrement, second strip and compare, where each strip step clears one 32-bit
// chunk of zeros at most; the single tripling adder sets the rate.
// Reset is synchronous, active low. A two-entry queue lets the front accept while
// the back iterates; the result register holds until popped, stalling the back end.
`default_nettype none
module collatz_glide_counter_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_push,
  output logic                  in_full,
  input  wire cgc_pkg::cgc_in_t in_data,
  output logic                  out_empty,
  input  wire                   out_pop,
  output cgc_pkg::cgc_out_t     out_data,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire                   cfg_paddr,
  input  wire [31:0]            cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import cgc_pkg::*;
  logic [15:0] limit_r;
  logic job_valid, job_take;
  cgc_job_t job;

  // step limit register, single word at address 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 32'd0 : {16'd0, limit_r};
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr)
      limit_r <= cfg_pwdata[15:0];
  end

  cgc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .job_valid, .job, .job_take
  );

  cgc_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_take,
    .step_limit(limit_r), .out_empty, .out_pop, .out_data
  );
endmodule
`default_nettype wire

// ===== rtl/cgc_front.sv =====
// Front end: accepts start numbers, classifies them, queues jobs for the back end.
// Depends on cgc_pkg.
`default_nettype none
module cgc_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_push,
  output logic                  in_full,
  input  wire cgc_pkg::cgc_in_t in_data,
  output logic                  job_valid,
  output cgc_pkg::cgc_job_t     job,
  input  wire                   job_take
);
  import cgc_pkg::*;
  cgc_job_t q_r [Q_DEPTH];
  logic rd_r, wr_r, rd_nxt, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cgc_job_t nj;
  logic do_push, do_pop;

  // classify by the two low bits
  always_comb begin
    nj.start = {in_data.start_high[HIGH_BITS-1:0], in_data.start_low};
    nj.restart = in_data.restart_total;
    if (!in_data.start_low[0]) nj.cls = CLS_EVEN;
    else if (!in_data.start_low[1]) nj.cls = CLS_ONE;
    else nj.cls = CLS_ITER;
  end

  assign in_full = (cnt_r == 2'(Q_DEPTH));
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];
  assign do_push = in_push && !in_full;
  assign do_pop = job_take && job_valid;

  always_comb begin
    rd_nxt = do_pop ? ~rd_r : rd_r;
    wr_nxt = do_push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= nj;
  end
endmodule
`default_nettype wire

// ===== rtl/cgc_back.sv =====
// Back end: iterative glide search with a single tripling adder, total and result register.
// Depends on cgc_pkg.
`default_nettype none
module cgc_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    job_valid,
  input  wire cgc_pkg::cgc_job_t job,
  output logic                   job_take,
  input  wire [15:0]             step_limit,
  output logic                   out_empty,
  input  wire                    out_pop,
  output cgc_pkg::cgc_out_t      out_data
);
  import cgc_pkg::*;
  cgc_state_t st_r, st_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt, s_r, s_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic [ALPHA_BITS-1:0] a_r, a_nxt;
  logic ovf_r, ovf_nxt, lim_r, lim_nxt;
  logic [63:0] total_r, total_nxt;
  logic full_r, full_nxt;
  cgc_out_t res_r, res_nxt;
  logic [VALUE_BITS+1:0] trip;
  logic [VALUE_BITS:0] inc;
  logic [STEP_BITS:0] cnt_p2;
  logic [15:0] lim16;
  logic [STEP_BITS:0] lim_eff;
  logic [64:0] sum;
  logic [5:0] tz;
  logic tz_any;

  // trailing zeros within the low 32 bits, one chunk a cycle while stripping
  always_comb begin
    tz = 6'd32;
    tz_any = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (v_r[i]) begin tz = 6'(i); tz_any = 1'b1; end
    end
  end

  assign trip = {2'b00, v_r} + {1'b0, v_r, 1'b0};
  assign inc = {1'b0, v_r} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign cnt_p2 = {1'b0, cnt_r} + (STEP_BITS+1)'(2);
  assign lim16 = step_limit;
  assign lim_eff = (STEP_BITS+1)'(lim16);
  assign sum = {1'b0, total_r} + 65'(cnt_r);
  assign job_take = (st_r == ST_IDLE) && job_valid && !full_r;
  assign out_empty = !full_r;
  assign out_data = res_r;

  always_comb begin
    st_nxt = st_r; v_nxt = v_r; s_nxt = s_r; cnt_nxt = cnt_r; a_nxt = a_r;
    ovf_nxt = ovf_r; lim_nxt = lim_r; total_nxt = total_r;
    full_nxt = full_r; res_nxt = res_r;
    if (out_pop && full_r) full_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (job_take) begin
          v_nxt = job.start; s_nxt = job.start;
          ovf_nxt = 1'b0; lim_nxt = 1'b0; a_nxt = '0;
          if (job.restart) total_nxt = '0;
          if (job.cls == CLS_EVEN) begin cnt_nxt = STEP_BITS'(1); st_nxt = ST_DONE; end
          else if (job.cls == CLS_ONE) begin cnt_nxt = STEP_BITS'(2); st_nxt = ST_DONE; end
          else begin cnt_nxt = '0; st_nxt = ST_INC; end
        end
      end
      // limit check, count two steps, add one
      ST_INC: begin
        if (cnt_p2 > lim_eff) begin lim_nxt = 1'b1; st_nxt = ST_DONE; end
        else begin
          cnt_nxt = cnt_p2[STEP_BITS-1:0];
          v_nxt = inc[VALUE_BITS-1:0];
          a_nxt = '0;
          if (inc[VALUE_BITS-1:0] == '0) begin ovf_nxt = 1'b1; st_nxt = ST_DONE; end
          else st_nxt = ST_STRIP_A;
        end
      end
      // strip trailing zeros, counting alpha
      ST_STRIP_A: begin
        v_nxt = v_r >> tz;
        a_nxt = a_r + ALPHA_BITS'(tz);
        if (tz_any) begin
          if (a_nxt >= ALPHA_BITS'(POW3_TABLE_LEN)) begin
            ovf_nxt = 1'b1; st_nxt = ST_DONE;
          end else if (a_nxt == '0) st_nxt = ST_DEC;
          else st_nxt = ST_MUL;
        end
      end
      // multiply by 3, one tripling a cycle
      ST_MUL: begin
        if (trip[VALUE_BITS+1:VALUE_BITS] != 2'b00) begin
          ovf_nxt = 1'b1; st_nxt = ST_DONE;
        end else begin
          v_nxt = trip[VALUE_BITS-1:0];
          a_nxt = a_r - ALPHA_BITS'(1);
          if (a_r == ALPHA_BITS'(1)) st_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        v_nxt = v_r - VALUE_BITS'(1);
        st_nxt = ST_STRIP_B;
      end
      ST_STRIP_B: begin
        if (v_r == '0) st_nxt = ST_CMP;
        else begin
          v_nxt = v_r >> tz;
          if (tz_any) st_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        st_nxt = (v_r < s_r) ? ST_DONE : ST_INC;
      end
      // write the result once the output register is free
      ST_DONE: begin
        if (!full_r || (out_pop && full_r)) begin
          if (!ovf_r && !lim_r) total_nxt = sum[64] ? '1 : sum[63:0];
          res_nxt.glide_steps = 16'(cnt_r);
          res_nxt.overflow = ovf_r;
          res_nxt.limit_hit = lim_r;
          res_nxt.step_total = total_nxt;
          full_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; total_r <= '0; full_r <= 1'b0; cnt_r <= '0;
      ovf_r <= 1'b0; lim_r <= 1'b0;
    end else begin
      st_r <= st_nxt; total_r <= total_nxt; full_r <= full_nxt; cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt; lim_r <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt; s_r <= s_nxt; a_r <= a_nxt; res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/cgc_checker.sv =====
// Port-level checker for the Collatz glide counter, bound to the top level.
// Depends on cgc_pkg.
`default_nettype none
module cgc_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_full,
  input wire                    out_empty,
  input wire                    out_pop,
  input wire cgc_pkg::cgc_out_t out_data
);
  // a flagged result never carries both flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_data.overflow && out_data.limit_hit)) else $error("both flags");
  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data)) else $error("result changed");
  // nothing shows right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not empty after reset");
  // a result without the limit flag has nonzero steps
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.limit_hit) |-> out_data.glide_steps != 16'd0)
    else $error("zero steps");
endmodule

bind collatz_glide_counter_unit cgc_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);
`default_nettype wire

// ===== tb/collatz_glide_counter_unit_test.sv =====
// Testbench for collatz_glide_counter_unit: random and directed start numbers,
// step-limit changes over APB, glide results checked against an inline predictor.
// Depends on cgc_pkg and the collatz_glide_counter_unit RTL.
`default_nettype none
module collatz_glide_counter_unit_test;
  import cgc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  cgc_in_t     in_data;
  logic        out_empty;
  logic        out_pop;
  cgc_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic        cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam logic CFG_STEP_LIMIT = 1'b0;

  collatz_glide_counter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [15:0] limit_q;
  logic [63:0] total_q;

  cgc_in_t  start_q[$];
  cgc_out_t glide_q[$];
  int       errors;
  bit       idle_on;
  bit       in_acc;
  bit       out_acc;
  int       in_gap;
  int       out_stall;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // glide of one start, updates the running total
  function automatic cgc_out_t glide_predict(cgc_in_t it);
    logic [127:0] s;
    logic [127:0] v;
    logic [129:0] p;
    logic [64:0]  sum;
    int unsigned  steps;
    int           a;
    bit           ovf;
    bit           lim;
    cgc_out_t     r;
    if (it.restart_total) total_q = '0;
    s = {it.start_high, it.start_low};
    v = s;
    steps = 0;
    ovf = 0;
    lim = 0;
    if (!s[0]) steps = 1;
    else if (!s[1]) steps = 2;
    else begin
      while (1) begin
        if (steps + 2 > limit_q) begin lim = 1; break; end
        steps += 2;
        v = v + 1;
        if (v == '0) begin ovf = 1; break; end
        a = 0;
        while (!v[0]) begin
          v = v >> 1;
          a++;
        end
        if (a >= POW3_TABLE_LEN) begin ovf = 1; break; end
        for (int i = 0; i < a && !ovf; i++) begin
          p = {2'b00, v} * 3;
          if (p[129:128] != 2'b00) ovf = 1;
          v = p[127:0];
        end
        if (ovf) break;
        v = v - 1;
        if (v != '0) while (!v[0]) v = v >> 1;
        if (v < s) break;
      end
    end
    if (!ovf && !lim) begin
      sum = {1'b0, total_q} + 65'(steps);
      total_q = sum[64] ? '1 : sum[63:0];
    end
    r.glide_steps = steps[15:0];
    r.overflow = ovf;
    r.limit_hit = lim;
    r.step_total = total_q;
    return r;
  endfunction

  // sender: one start per transaction, random gap after each while idle_on is set
  always @(negedge clk) begin
    logic nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      nxt = in_push;
      if (in_push && in_acc) nxt = 1'b0;
      if (!nxt) begin
        if (in_gap > 0) in_gap--;
        else if (start_q.size() != 0) begin
          in_data <= start_q.pop_front();
          nxt = 1'b1;
          in_gap = idle_on ? $urandom_range(0, 12) : 0;
        end
      end
      in_push <= nxt;
    end
  end

  // receiver: random stall before each pop while idle_on is set
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_acc) out_stall = idle_on ? $urandom_range(0, 12) : 0;
      else if (out_stall > 0) out_stall--;
      out_pop <= (out_stall == 0);
    end
  end

  // monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    cgc_out_t want;
    in_acc <= rst_n && in_push && !in_full;
    out_acc <= rst_n && out_pop && !out_empty;
    if (rst_n && in_push && !in_full) glide_q.push_back(glide_predict(in_data));
    if (rst_n && out_pop && !out_empty) begin
      if (glide_q.size() == 0) begin
        if (errors < 10) $display("unexpected result %p", out_data);
        errors++;
      end else begin
        want = glide_q.pop_front();
        if (want.glide_steps !== out_data.glide_steps || want.overflow !== out_data.overflow
            || want.limit_hit !== out_data.limit_hit
            || want.step_total !== out_data.step_total) begin
          if (errors < 10)
            $display({"mismatch: expected steps=%0d ovf=%b lim=%b total=%0d,",
                      " got steps=%0d ovf=%b lim=%b total=%0d"},
                     want.glide_steps, want.overflow, want.limit_hit, want.step_total,
                     out_data.glide_steps, out_data.overflow, out_data.limit_hit,
                     out_data.step_total);
          errors++;
        end
      end
    end
  end

  task automatic add_start(logic [127:0] s, bit restart);
    cgc_in_t it;
    it.start_low = s[63:0];
    it.start_high = s[127:64];
    it.restart_total = restart;
    start_q.push_back(it);
  endtask

  // random start, mostly 3 mod 4 of random bit length
  task automatic add_random;
    logic [127:0] s;
    int           len;
    int           k;
    s = {$urandom, $urandom, $urandom, $urandom};
    len = $urandom_range(2, 128);
    if (len < 128) s = s & ((128'd1 << len) - 1);
    case ($urandom_range(0, 9))
      0: s[0] = 1'b0;
      1: s[1:0] = 2'b01;
      2: begin
        k = $urandom_range(2, 127);
        s = (s << k) | ((128'd1 << k) - 1);
      end
      default: s[1:0] = 2'b11;
    endcase
    add_start(s, $urandom_range(0, 7) == 0);
  endtask

  // sampled at the rising edge so a start just handed to the sender is seen
  task automatic wait_idle;
    do @(posedge clk);
    while (start_q.size() != 0 || in_push || glide_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= CFG_STEP_LIMIT;
    cfg_pwdata <= {16'h0, val}; cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    limit_q = val;
  endtask

  initial begin
    logic [15:0] limits[7];
    rst_n = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = CFG_STEP_LIMIT; cfg_pwdata = '0;
    limit_q = LIMIT_RESET;
    total_q = '0;
    errors = 0;
    idle_on = 1'b1;
    in_gap = 0;
    out_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: field extremes, shortcut classes, overflow causes
    add_start(128'd0, 1'b0);
    add_start(128'd1, 1'b0);
    add_start(128'd2, 1'b0);
    add_start(128'd3, 1'b0);
    add_start(128'd7, 1'b1);
    add_start(128'd27, 1'b0);
    add_start({128{1'b1}}, 1'b0);                  // +1 carries out
    add_start((128'd1 << 100) - 1, 1'b0);          // alpha past POW3_TABLE_LEN
    add_start((128'd1 << 80) - 1, 1'b0);           // alpha just under POW3_TABLE_LEN
    add_start((128'd1 << 127) | ((128'd1 << 60) - 1), 1'b0); // product too wide
    add_start({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 1'b1);
    add_start({64'h0, 64'hFFFF_FFFF_FFFF_FFFD}, 1'b0);
    add_start({64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0);
    add_start({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB}, 1'b1);
    wait_idle();

    // step limit sweep, extremes included
    limits = '{16'd1, 16'd0, 16'd2, 16'd7, 16'd40, 16'hFFFF, 16'd0};
    limits[6] = 16'($urandom_range(3, 200));
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 0) add_start(128'd3, 1'b0);
      idle_on = (p != 3);
      repeat (90) add_random();
      wait_idle();
    end
    write_limit(LIMIT_RESET);
    idle_on = 1'b1;
    repeat (10) add_random();
    wait_idle();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // final message on leftover expectations is covered by wait_idle; this is the hard stop
  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/cgc_pkg.sv
rtl/cgc_front.sv
rtl/cgc_back.sv
rtl/collatz_glide_counter_unit.sv
rtl/cgc_checker.sv
tb/collatz_glide_counter_unit_test.sv
